[rtl/etnm_pkg.sv]
`default_nettype none

package etnm_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int NODE_BITS_DEF     = 16;

    typedef enum logic [1:0] {
        OP_SET_EDGE = 2'd0,
        OP_SET_TRI  = 2'd1,
        OP_LOOKUP   = 2'd2,
        OP_UNUSED   = 2'd3
    } opcode_t;

    // edge step within a triangle: (a,b)->c, (b,c)->a, (c,a)->b
    typedef enum logic [1:0] {
        STEP_AB = 2'd0,
        STEP_BC = 2'd1,
        STEP_CA = 2'd2
    } step_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

endpackage

`default_nettype wire

[rtl/etnm_ram.sv]
`default_nettype none

module etnm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/edge_to_node_map.sv]
`default_nettype none

// Edge table: maps an ordered node pair to a node. An item is taken when start
// is high and busy is low; its one result appears for a single cycle with
// strobe high and must be taken then, since the receiver cannot stall. All
// entries live in one single-port-write, registered-read RAM that is searched
// linearly, one stored entry per cycle. An edge search reads only the n occupied
// slots and ends on the first match or after the last stored entry; a set edge
// or lookup is one search, a set triangle is three in turn, and busy stays
// high until the last search ends. The result follows in the
// cycle after the last search. An unused opcode does not raise busy and gives
// its result in the cycle after it is taken. The RAM read port walking the
// occupied slots sets the search length. Reset empties the table at once through the
// fill count; there is no clearing pass.

module edge_to_node_map #(
    parameter int TABLE_ENTRIES = etnm_pkg::TABLE_ENTRIES_DEF,
    parameter int NODE_BITS     = etnm_pkg::NODE_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           opcode,
    input  wire logic [NODE_BITS-1:0] node_a,
    input  wire logic [NODE_BITS-1:0] node_b,
    input  wire logic [NODE_BITS-1:0] node_c,
    output logic                      strobe,
    output logic                      found,
    output logic [NODE_BITS-1:0]      node_value,
    output logic                      table_full
);

    localparam int ADDR_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(TABLE_ENTRIES + 1);
    localparam int MEM_WIDTH = 3 * NODE_BITS;
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(TABLE_ENTRIES);

    etnm_pkg::state_t  state_reg, state_next;
    etnm_pkg::opcode_t op_reg, op_next;
    etnm_pkg::step_t   step_reg, step_next;

    logic [NODE_BITS-1:0] a_reg, a_next;
    logic [NODE_BITS-1:0] b_reg, b_next;
    logic [NODE_BITS-1:0] c_reg, c_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;
    logic [CNT_BITS-1:0]  cmp_idx_reg, cmp_idx_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 drop_reg, drop_next;

    logic                 strobe_reg, strobe_next;
    logic                 found_reg, found_next;
    logic [NODE_BITS-1:0] value_reg, value_next;
    logic                 full_reg, full_next;

    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [MEM_WIDTH-1:0] mem_wdata;
    logic [ADDR_BITS-1:0] mem_raddr;
    logic [MEM_WIDTH-1:0] mem_rdata;

    logic [NODE_BITS-1:0] key1, key2, val;
    logic                 accept;
    logic                 match;
    logic                 scan_more;
    logic                 scan_miss;
    logic                 step_last;
    logic                 item_done;

    etnm_ram #(
        .WIDTH(MEM_WIDTH),
        .DEPTH(TABLE_ENTRIES),
        .ADDR_BITS(ADDR_BITS)
    ) u_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign busy   = (state_reg == etnm_pkg::ST_SCAN);
    assign accept = start && !busy;

    // key pair and value for the current edge step
    always_comb
    begin
        case (step_reg)
            etnm_pkg::STEP_BC:
            begin
                key1 = b_reg;
                key2 = c_reg;
                val  = a_reg;
            end
            etnm_pkg::STEP_CA:
            begin
                key1 = c_reg;
                key2 = a_reg;
                val  = b_reg;
            end
            default:
            begin
                key1 = a_reg;
                key2 = b_reg;
                val  = c_reg;
            end
        endcase
    end

    // data read last cycle is compared this cycle
    assign match = cmp_vld_reg
                && (mem_rdata[MEM_WIDTH-1 -: NODE_BITS] == key1)
                && (mem_rdata[2*NODE_BITS-1 -: NODE_BITS] == key2);
    assign scan_more = (idx_reg < count_reg);
    assign scan_miss = !match && !scan_more;
    assign step_last = (op_reg != etnm_pkg::OP_SET_TRI) || (step_reg == etnm_pkg::STEP_CA);
    assign item_done = (match || scan_miss) && step_last;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            etnm_pkg::ST_IDLE:
            begin
                if (accept && (etnm_pkg::opcode_t'(opcode) != etnm_pkg::OP_UNUSED))
                begin
                    state_next = etnm_pkg::ST_SCAN;
                end
            end
            etnm_pkg::ST_SCAN:
            begin
                if (item_done)
                begin
                    state_next = etnm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = etnm_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next      = op_reg;
        step_next    = step_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        idx_next     = idx_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = 1'b0;
        count_next   = count_reg;
        drop_next    = drop_reg;
        strobe_next  = 1'b0;
        found_next   = found_reg;
        value_next   = value_reg;
        full_next    = full_reg;
        mem_we       = 1'b0;
        mem_waddr    = cmp_idx_reg[ADDR_BITS-1:0];
        mem_wdata    = {key1, key2, val};
        mem_raddr    = idx_reg[ADDR_BITS-1:0];

        unique case (state_reg)
            etnm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = etnm_pkg::opcode_t'(opcode);
                    a_next    = node_a;
                    b_next    = node_b;
                    c_next    = node_c;
                    step_next = etnm_pkg::STEP_AB;
                    idx_next  = '0;
                    drop_next = 1'b0;
                    if (etnm_pkg::opcode_t'(opcode) == etnm_pkg::OP_UNUSED)
                    begin
                        strobe_next = 1'b1;
                        found_next  = 1'b0;
                        value_next  = '0;
                        full_next   = 1'b0;
                    end
                end
            end
            etnm_pkg::ST_SCAN:
            begin
                if (match || scan_miss)
                begin
                    logic dropped;
                    dropped = 1'b0;
                    if (op_reg != etnm_pkg::OP_LOOKUP)
                    begin
                        if (match)
                        begin
                            // update the node of the stored pair
                            mem_we    = 1'b1;
                            mem_waddr = cmp_idx_reg[ADDR_BITS-1:0];
                        end
                        else if (count_reg < FULL_COUNT)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[ADDR_BITS-1:0];
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            dropped = 1'b1;
                        end
                    end
                    drop_next = drop_reg || dropped;
                    idx_next  = '0;
                    step_next = etnm_pkg::step_t'(step_reg + 1'b1);
                    if (step_last)
                    begin
                        strobe_next = 1'b1;
                        found_next  = (op_reg == etnm_pkg::OP_LOOKUP) && match;
                        value_next  = ((op_reg == etnm_pkg::OP_LOOKUP) && match)
                                    ? mem_rdata[NODE_BITS-1:0] : '0;
                        full_next   = drop_reg || dropped;
                    end
                end
                else
                begin
                    // issue the read of the next occupied slot
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg;
                    idx_next     = idx_reg + 1'b1;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= etnm_pkg::ST_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        step_reg    <= step_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        drop_reg    <= drop_next;
        found_reg   <= found_next;
        value_reg   <= value_next;
        full_reg    <= full_next;
    end

    assign strobe     = strobe_reg;
    assign found      = found_reg;
    assign node_value = value_reg;
    assign table_full = full_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond table size");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == CNT_BITS'($past(count_reg) + 1'b1)))
        else $error("entry count moved by more than one");

    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == etnm_pkg::ST_SCAN))
        else $error("table write outside a search");

    a_hit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !(found && table_full))
        else $error("lookup hit reported together with a dropped insert");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("result raised while a search is running");

endmodule

`default_nettype wire
